>>> hdl/assert_macros.svh
// assertion macros shared by the sequencer rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define I2CMTS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequence that must hold in the cycle after the trigger
`define I2CMTS_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

>>> hdl/i2cmts_pkg.sv
// shared types, codes and widths of the i2c master transfer sequencer
// no dependencies; used by all sequencer modules
`default_nettype none

package i2cmts_pkg;

	// sizes
	localparam int BUF_DEPTH_DEF = 16;
	localparam int MODE_W        = 3;
	localparam int ADDR_W        = 7;
	localparam int LEN_W         = 5;
	localparam int BYTE_W        = 8;
	localparam int LIDX_W        = 4;
	localparam int PHASE_W       = 3;
	localparam int IN_DATA_W     = 40;
	localparam int OUT_DATA_W    = 32;

	// item kinds
	localparam logic [MODE_W-1:0] MODE_RESERVE = 3'd0;
	localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd1;
	localparam logic [MODE_W-1:0] MODE_WRITE   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_READ    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_EVENT   = 3'd4;
	localparam logic [MODE_W-1:0] MODE_LOAD    = 3'd5;

	// sequencer phases
	localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd0;
	localparam logic [PHASE_W-1:0] PH_WR_START = 3'd1;
	localparam logic [PHASE_W-1:0] PH_WR_ADDR  = 3'd2;
	localparam logic [PHASE_W-1:0] PH_WR_DATA  = 3'd3;
	localparam logic [PHASE_W-1:0] PH_RD_START = 3'd4;
	localparam logic [PHASE_W-1:0] PH_RD_ADDR  = 3'd5;
	localparam logic [PHASE_W-1:0] PH_RD_DATA  = 3'd6;

	// return codes
	localparam logic [1:0] RC_OK           = 2'd0;
	localparam logic [1:0] RC_WRONG_STATE  = 2'd1;
	localparam logic [1:0] RC_NOT_RESERVED = 2'd2;
	localparam logic [1:0] RC_RESERVED     = 2'd3;

	// ack and enable/irq control codes
	localparam logic [1:0] ACK_NONE = 2'd0;
	localparam logic [1:0] ACK_ACK  = 2'd1;
	localparam logic [1:0] ACK_NACK = 2'd2;
	localparam logic [1:0] CTL_NONE = 2'd0;
	localparam logic [1:0] CTL_ON   = 2'd1;
	localparam logic [1:0] CTL_OFF  = 2'd2;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [ADDR_W-1:0] target_address;
		logic [LEN_W-1:0]  transfer_length;
		logic              flag_start_sent;
		logic              flag_address_acked;
		logic              flag_tx_empty;
		logic              flag_byte_finished;
		logic              flag_rx_full;
		logic [BYTE_W-1:0] rx_data;
		logic [LIDX_W-1:0] load_index;
		logic [BYTE_W-1:0] load_value;
	} item_t;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic               bus_reserved;
		logic [ADDR_W-1:0]  saved_address;
		logic [LEN_W-1:0]   saved_length;
		logic [LEN_W-1:0]   bytes_done;
	} state_t;

	typedef struct packed {
		logic [1:0]        return_code;
		logic              tx_valid;
		logic [BYTE_W-1:0] tx_byte;
		logic              start_request;
		logic              stop_request;
		logic [1:0]        ack_control;
		logic [1:0]        enable_control;
		logic [1:0]        irq_control;
		logic              clear_address_flag;
		logic              rx_valid;
		logic [BYTE_W-1:0] rx_byte;
		logic              busy_res;
	} result_t;

	typedef struct packed {
		logic              en;
		logic [LIDX_W-1:0] idx;
		logic [BYTE_W-1:0] value;
	} buf_wr_t;

endpackage

`default_nettype wire

>>> hdl/i2cmts_buf.sv
// message buffer with a prefetched read port and write forwarding
// depends on i2cmts_pkg
`default_nettype none

module i2cmts_buf #(
	parameter int BUF_DEPTH = i2cmts_pkg::BUF_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire i2cmts_pkg::buf_wr_t           wr,
	input  wire logic [i2cmts_pkg::LEN_W-1:0]  rd_idx,
	output logic      [i2cmts_pkg::BYTE_W-1:0] rd_byte
);

	localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam int CW = ((AW > i2cmts_pkg::LEN_W) ? AW : i2cmts_pkg::LEN_W) + 1;

	logic [i2cmts_pkg::BYTE_W-1:0] mem [BUF_DEPTH];
	logic [i2cmts_pkg::BYTE_W-1:0] rd_byte_q;
	logic [CW-1:0]                 wr_wide;
	logic [CW-1:0]                 rd_wide;
	logic [AW-1:0]                 wr_addr;
	logic [AW-1:0]                 rd_addr;
	logic                          wr_ok;

	// drop writes past the end, park reads past the end on entry zero
	always_comb begin
		wr_wide = CW'(wr.idx);
		rd_wide = CW'(rd_idx);
		wr_ok   = wr.en && (wr_wide < CW'(BUF_DEPTH));
		wr_addr = wr_wide[AW-1:0];
		rd_addr = (rd_wide < CW'(BUF_DEPTH)) ? rd_wide[AW-1:0] : '0;
	end

	// storage write and registered read of the next byte to send
	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[wr_addr] <= wr.value;
		end
		if (wr_ok && (wr_addr == rd_addr)) begin
			rd_byte_q <= wr.value;
		end else begin
			rd_byte_q <= mem[rd_addr];
		end
	end

	assign rd_byte = rd_byte_q;

endmodule

`default_nettype wire

>>> hdl/i2cmts_step.sv
// next-state and result logic for one item of the transfer sequencer
// depends on i2cmts_pkg
`default_nettype none

module i2cmts_step #(
	parameter int BUF_DEPTH = i2cmts_pkg::BUF_DEPTH_DEF
) (
	input  wire i2cmts_pkg::item_t             item,
	input  wire i2cmts_pkg::state_t            cur,
	input  wire logic [i2cmts_pkg::BYTE_W-1:0] buf_byte,
	output i2cmts_pkg::state_t                 nxt,
	output i2cmts_pkg::result_t                res,
	output i2cmts_pkg::buf_wr_t                wr
);

	localparam logic [i2cmts_pkg::LEN_W-1:0] LEN_MAX =
		(BUF_DEPTH > 31) ? 5'd31 : i2cmts_pkg::LEN_W'(BUF_DEPTH);

	logic [i2cmts_pkg::LEN_W-1:0] len_sat;
	logic [i2cmts_pkg::LEN_W-1:0] done_inc;

	// clamp the requested length to one..buffer depth, at most 31
	always_comb begin
		if (item.transfer_length == '0) begin
			len_sat = i2cmts_pkg::LEN_W'(1);
		end else if (item.transfer_length > LEN_MAX) begin
			len_sat = LEN_MAX;
		end else begin
			len_sat = item.transfer_length;
		end
		done_inc = cur.bytes_done + i2cmts_pkg::LEN_W'(1);
	end

	// command decode, status event sequencing and buffer loads
	always_comb begin
		nxt      = cur;
		res      = '0;
		wr.en    = 1'b0;
		wr.idx   = item.load_index;
		wr.value = item.load_value;
		unique case (item.mode) inside
			i2cmts_pkg::MODE_RESERVE: begin
				if (cur.bus_reserved) begin
					res.return_code = i2cmts_pkg::RC_RESERVED;
				end else begin
					nxt.bus_reserved = 1'b1;
				end
			end
			i2cmts_pkg::MODE_RELEASE: begin
				if (!cur.bus_reserved) begin
					res.return_code = i2cmts_pkg::RC_WRONG_STATE;
				end else begin
					nxt.bus_reserved = 1'b0;
				end
			end
			i2cmts_pkg::MODE_WRITE, i2cmts_pkg::MODE_READ: begin
				if (!cur.bus_reserved) begin
					res.return_code = i2cmts_pkg::RC_NOT_RESERVED;
				end else if (cur.phase != i2cmts_pkg::PH_IDLE) begin
					res.return_code = i2cmts_pkg::RC_WRONG_STATE;
				end else begin
					nxt.saved_address  = item.target_address;
					nxt.saved_length   = len_sat;
					nxt.bytes_done     = '0;
					nxt.phase          = (item.mode == i2cmts_pkg::MODE_WRITE) ?
						i2cmts_pkg::PH_WR_START : i2cmts_pkg::PH_RD_START;
					res.enable_control = i2cmts_pkg::CTL_ON;
					res.start_request  = 1'b1;
					res.irq_control    = i2cmts_pkg::CTL_ON;
				end
			end
			i2cmts_pkg::MODE_EVENT: begin
				unique case (cur.phase)
					i2cmts_pkg::PH_WR_START: begin
						if (item.flag_start_sent) begin
							res.tx_valid = 1'b1;
							res.tx_byte  = {cur.saved_address, 1'b0};
							nxt.phase    = i2cmts_pkg::PH_WR_ADDR;
						end
					end
					i2cmts_pkg::PH_WR_ADDR: begin
						if (item.flag_address_acked) begin
							res.clear_address_flag = 1'b1;
							res.tx_valid           = 1'b1;
							res.tx_byte            = buf_byte;
							nxt.bytes_done         = done_inc;
							nxt.phase              = i2cmts_pkg::PH_WR_DATA;
						end
					end
					i2cmts_pkg::PH_WR_DATA: begin
						if (item.flag_tx_empty || item.flag_byte_finished) begin
							if (cur.bytes_done < cur.saved_length) begin
								res.tx_valid   = 1'b1;
								res.tx_byte    = buf_byte;
								nxt.bytes_done = done_inc;
							end else if (item.flag_byte_finished) begin
								res.irq_control    = i2cmts_pkg::CTL_OFF;
								res.stop_request   = 1'b1;
								res.enable_control = i2cmts_pkg::CTL_OFF;
								nxt.phase          = i2cmts_pkg::PH_IDLE;
							end
						end
					end
					i2cmts_pkg::PH_RD_START: begin
						if (item.flag_start_sent) begin
							res.tx_valid = 1'b1;
							res.tx_byte  = {cur.saved_address, 1'b1};
							nxt.phase    = i2cmts_pkg::PH_RD_ADDR;
						end
					end
					i2cmts_pkg::PH_RD_ADDR: begin
						if (item.flag_address_acked) begin
							// single-byte read: nack and stop before the byte arrives
							if (cur.saved_length == i2cmts_pkg::LEN_W'(1)) begin
								res.ack_control  = i2cmts_pkg::ACK_NACK;
								res.stop_request = 1'b1;
							end else begin
								res.ack_control = i2cmts_pkg::ACK_ACK;
							end
							res.clear_address_flag = 1'b1;
							nxt.phase              = i2cmts_pkg::PH_RD_DATA;
						end
					end
					i2cmts_pkg::PH_RD_DATA: begin
						if (item.flag_rx_full) begin
							res.rx_valid   = 1'b1;
							res.rx_byte    = item.rx_data;
							nxt.bytes_done = done_inc;
							if (done_inc >= cur.saved_length) begin
								res.irq_control    = i2cmts_pkg::CTL_OFF;
								res.stop_request   = (cur.saved_length > i2cmts_pkg::LEN_W'(1));
								res.enable_control = i2cmts_pkg::CTL_OFF;
								nxt.phase          = i2cmts_pkg::PH_IDLE;
							end else if (done_inc ==
									cur.saved_length - i2cmts_pkg::LEN_W'(1)) begin
								// next byte is the last one
								res.ack_control  = i2cmts_pkg::ACK_NACK;
								res.stop_request = 1'b1;
							end
						end
					end
					default: begin
					end
				endcase
			end
			i2cmts_pkg::MODE_LOAD: begin
				wr.en = 1'b1;
			end
			default: begin
			end
		endcase
		res.busy_res = (nxt.phase != i2cmts_pkg::PH_IDLE);
	end

endmodule

`default_nettype wire

>>> hdl/i2c_master_transfer_sequencer_core.sv
// i2c master transfer sequencer: input register, step logic, buffer, result register
// the step stage sits between the input register and the result register
// throughput: one item per cycle while m_tready is high, set by the single step stage
// reset: arst_n clears the handshake state and the sequencer state (idle, not reserved)
// the message buffer is not cleared; a byte must be loaded before it is sent
// depends on i2cmts_pkg, i2cmts_step, i2cmts_buf and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module i2c_master_transfer_sequencer_core #(
	parameter int BUF_DEPTH = i2cmts_pkg::BUF_DEPTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// target_address, transfer_length, flag_start_sent, flag_address_acked,
	// flag_tx_empty, flag_byte_finished, flag_rx_full, rx_data, load_index,
	// load_value, zero pad
	input  wire logic [i2cmts_pkg::IN_DATA_W-1:0]  s_tdata,
	// mode
	input  wire logic [i2cmts_pkg::MODE_W-1:0]     s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// return_code, tx_valid, tx_byte, start_request, stop_request, ack_control,
	// enable_control, irq_control, clear_address_flag, rx_valid, rx_byte,
	// busy_res, zero pad
	output logic      [i2cmts_pkg::OUT_DATA_W-1:0] m_tdata
);

	i2cmts_pkg::item_t   item_in;
	i2cmts_pkg::item_t   item_s1;
	logic                valid_s1;
	i2cmts_pkg::state_t  state_q;
	i2cmts_pkg::state_t  state_nxt;
	i2cmts_pkg::state_t  state_d;
	i2cmts_pkg::result_t res;
	i2cmts_pkg::result_t res_q;
	logic                out_valid_q;
	i2cmts_pkg::buf_wr_t step_wr;
	i2cmts_pkg::buf_wr_t buf_wr;
	logic [i2cmts_pkg::BYTE_W-1:0] buf_byte;
	logic                adv;

	// unpack the input transfer
	always_comb begin
		item_in.mode               = s_tuser;
		item_in.target_address     = s_tdata[6:0];
		item_in.transfer_length    = s_tdata[11:7];
		item_in.flag_start_sent    = s_tdata[12];
		item_in.flag_address_acked = s_tdata[13];
		item_in.flag_tx_empty      = s_tdata[14];
		item_in.flag_byte_finished = s_tdata[15];
		item_in.flag_rx_full       = s_tdata[16];
		item_in.rx_data            = s_tdata[24:17];
		item_in.load_index         = s_tdata[28:25];
		item_in.load_value         = s_tdata[36:29];
	end

	// handshake: the item moves on when the result register is free or drains
	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_in;
		end
	end

	i2cmts_step #(
		.BUF_DEPTH(BUF_DEPTH)
	) u_step (
		.item    (item_s1),
		.cur     (state_q),
		.buf_byte(buf_byte),
		.nxt     (state_nxt),
		.res     (res),
		.wr      (step_wr)
	);

	// buffer writes and the prefetch address follow the committed state
	always_comb begin
		buf_wr    = step_wr;
		buf_wr.en = step_wr.en && adv;
		state_d   = adv ? state_nxt : state_q;
	end

	i2cmts_buf #(
		.BUF_DEPTH(BUF_DEPTH)
	) u_buf (
		.clk    (clk),
		.wr     (buf_wr),
		.rd_idx (state_d.bytes_done),
		.rd_byte(buf_byte)
	);

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: i2cmts_pkg::PH_IDLE, default: '0};
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	// pack the output transfer
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, res_q.busy_res, res_q.rx_byte, res_q.rx_valid,
		res_q.clear_address_flag, res_q.irq_control, res_q.enable_control,
		res_q.ack_control, res_q.stop_request, res_q.start_request,
		res_q.tx_byte, res_q.tx_valid, res_q.return_code};

	// checks
	`I2CMTS_ASSERT(a_done_le_len, clk, arst_n,
		state_q.bytes_done <= state_q.saved_length,
		"byte count passed the transfer length")
	`I2CMTS_ASSERT(a_busy_len, clk, arst_n,
		(state_q.phase == i2cmts_pkg::PH_IDLE) || (state_q.saved_length != '0),
		"active transfer with zero length")
	`I2CMTS_ASSERT(a_busy_match, clk, arst_n,
		!out_valid_q || (res_q.busy_res == (state_q.phase != i2cmts_pkg::PH_IDLE)),
		"presented busy flag disagrees with the sequencer phase")
	`I2CMTS_ASSERT(a_tx_rx_excl, clk, arst_n,
		!out_valid_q || !(res_q.tx_valid && res_q.rx_valid),
		"transmit and receive byte in the same result")
	`I2CMTS_ASSERT_NEXT(a_load_phase, clk, arst_n,
		adv && (item_s1.mode == i2cmts_pkg::MODE_LOAD),
		$stable(state_q.phase),
		"buffer load changed the sequencer phase")

endmodule

`default_nettype wire
